[hw/rtl/eorf_pkg.sv]
// Shared constants and types for the echo outlier-rejecting filter.
// Used by every module in hw/rtl; no dependencies.
package eorf_pkg;

    localparam int ECHO_W = 20;
    localparam int DIST_W = 19;
    localparam int TRY_W  = 4;

    localparam int RING_DEPTH = 3;
    localparam int POS_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    // mean = floor(sum / RING_DEPTH) via round-up reciprocal, exact for SUM_W-bit sums
    localparam int MEAN_L       = $clog2(RING_DEPTH);
    localparam int SUM_W        = ECHO_W + MEAN_L;
    localparam int MEAN_SH      = SUM_W + MEAN_L;
    localparam int MEAN_RECIP_W = SUM_W + 1;
    localparam longint unsigned MEAN_RECIP_VAL =
        ((64'd1 << MEAN_SH) + RING_DEPTH - 1) / RING_DEPTH;
    localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP = MEAN_RECIP_W'(MEAN_RECIP_VAL);

    // distance_q4 = floor(echo * 80 / 291); echo * 80 is formed by shift-add
    localparam int DIST_DIV     = 291;
    localparam int DIST_X_W     = ECHO_W + 7;
    localparam int DIST_L       = $clog2(DIST_DIV);
    localparam int DIST_SH      = DIST_X_W + DIST_L;
    localparam int DIST_RECIP_W = DIST_X_W + 1;
    localparam longint unsigned DIST_RECIP_VAL =
        ((64'd1 << DIST_SH) + DIST_DIV - 1) / DIST_DIV;
    localparam logic [DIST_RECIP_W-1:0] DIST_RECIP = DIST_RECIP_W'(DIST_RECIP_VAL);

    localparam logic [ECHO_W-1:0] DEV_LIMIT_RST   = ECHO_W'(2000);
    localparam logic [TRY_W-1:0]  RETRY_LIMIT_RST = TRY_W'(5);

    typedef enum logic [0:0] {
        CFG_DEV_LIMIT   = 1'b0,
        CFG_RETRY_LIMIT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic              we;
        logic [ECHO_W-1:0] data;
    } ring_wr_t;

    typedef struct packed {
        logic              has_mean;
        logic [ECHO_W-1:0] mean;
    } ring_stat_t;

endpackage

[hw/rtl/echo_outlier_rejecting_filter.sv]
// Echo outlier-rejecting filter, top level.
// A request is registered in the input reg, then its result in the result reg.
// Throughput: one request per cycle unless output stalls; ring compares and updates at once.
// Requests rejected or discarded produce no result.
// Reset (rst_n low, async): ring, pointer, try count cleared; limits to 2000 and 5.
// Depends on eorf_pkg, eorf_ring, eorf_dist.
module echo_outlier_rejecting_filter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [eorf_pkg::ECHO_W-1:0]  raw_echo,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [eorf_pkg::ECHO_W-1:0]  accepted_echo,
    output logic [eorf_pkg::DIST_W-1:0]  distance_q4,
    output logic                         forced_accept,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  eorf_pkg::cfg_index_t         cfg_index,
    input  logic [eorf_pkg::ECHO_W-1:0]  cfg_data
);
    import eorf_pkg::*;

    logic              s1_valid_reg;
    logic [ECHO_W-1:0] s1_echo_reg;
    logic              s1_go;

    logic [ECHO_W-1:0] dev_limit_reg;
    logic [TRY_W-1:0]  retry_limit_reg;
    logic [TRY_W-1:0]  try_reg;
    logic [TRY_W-1:0]  try_next;
    logic              after_rej_reg;
    logic              after_rej_next;

    logic              out_valid_reg;
    logic [ECHO_W-1:0] echo_out_reg;
    logic [DIST_W-1:0] dist_out_reg;
    logic              forced_reg;

    ring_wr_t          ring_wr;
    ring_stat_t        ring_stat;
    logic [ECHO_W-1:0] delta;
    logic              emit;
    logic              forced;
    logic [DIST_W-1:0] dist_q4;

    eorf_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (ring_wr),
        .stat  (ring_stat)
    );

    eorf_dist u_dist (
        .echo    (s1_echo_reg),
        .dist_q4 (dist_q4)
    );

    assign s1_go     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_go;
    assign cfg_ready = 1'b1;

    assign delta = (s1_echo_reg >= ring_stat.mean) ? s1_echo_reg - ring_stat.mean
                                                   : ring_stat.mean - s1_echo_reg;

    always_comb
    begin
        emit           = 1'b0;
        forced         = 1'b0;
        try_next       = try_reg;
        after_rej_next = after_rej_reg;
        if (s1_go)
        begin
            if (after_rej_reg)
            begin
                // reading after a rejection: discarded unless retry limit reached
                after_rej_next = 1'b0;
                if (try_reg >= retry_limit_reg)
                begin
                    emit   = 1'b1;
                    forced = 1'b1;
                end
            end
            else if (!ring_stat.has_mean || (delta < dev_limit_reg))
            begin
                emit = 1'b1;
            end
            else
            begin
                try_next       = try_reg + TRY_W'(1);
                after_rej_next = 1'b1;
            end
            if (emit)
            begin
                try_next = '0;
            end
        end
    end

    assign ring_wr.we   = emit;
    assign ring_wr.data = s1_echo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            try_reg         <= '0;
            after_rej_reg   <= 1'b0;
            dev_limit_reg   <= DEV_LIMIT_RST;
            retry_limit_reg <= RETRY_LIMIT_RST;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_go)
            begin
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            try_reg       <= try_next;
            after_rej_reg <= after_rej_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_DEV_LIMIT:   dev_limit_reg   <= cfg_data;
                    CFG_RETRY_LIMIT: retry_limit_reg <= cfg_data[TRY_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_echo_reg <= raw_echo;
        end
        if (emit)
        begin
            echo_out_reg <= s1_echo_reg;
            dist_out_reg <= dist_q4;
            forced_reg   <= forced;
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted_echo = echo_out_reg;
    assign distance_q4   = dist_out_reg;
    assign forced_accept = forced_reg;

endmodule

[hw/rtl/eorf_ring.sv]
// History ring of accepted echo widths, write pointer and truncated mean.
// Depends on eorf_pkg.
module eorf_ring (
    input  logic                  clk,
    input  logic                  rst_n,
    input  eorf_pkg::ring_wr_t    wr,
    output eorf_pkg::ring_stat_t  stat
);
    import eorf_pkg::*;

    localparam int PROD_W = SUM_W + MEAN_RECIP_W;

    logic [ECHO_W-1:0] ring_reg [RING_DEPTH];
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [SUM_W-1:0]  sum;
    logic              all_nz;
    logic [PROD_W-1:0] prod;
    logic [ECHO_W-1:0] mean;

    always_comb
    begin
        sum    = '0;
        all_nz = 1'b1;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            sum    = sum + SUM_W'(ring_reg[i]);
            all_nz = all_nz & (|ring_reg[i]);
        end
    end

    assign prod = PROD_W'(sum) * PROD_W'(MEAN_RECIP);
    assign mean = prod[MEAN_SH +: ECHO_W];

    assign stat.has_mean = all_nz && (|mean);
    assign stat.mean     = mean;

    assign pos_next = (pos_reg == POS_W'(RING_DEPTH - 1)) ? '0 : pos_reg + POS_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            pos_reg <= '0;
        end
        else if (wr.we)
        begin
            ring_reg[pos_reg] <= wr.data;
            pos_reg           <= pos_next;
        end
    end

endmodule

[hw/rtl/eorf_dist.sv]
// Echo width to distance in cm with 4 fraction bits, floor(echo * 80 / 291).
// Depends on eorf_pkg.
module eorf_dist (
    input  logic [eorf_pkg::ECHO_W-1:0] echo,
    output logic [eorf_pkg::DIST_W-1:0] dist_q4
);
    import eorf_pkg::*;

    localparam int PROD_W = DIST_X_W + DIST_RECIP_W;

    logic [DIST_X_W-1:0] x;
    logic [PROD_W-1:0]   prod;

    // echo * 80 = echo * 64 + echo * 16
    assign x       = {1'b0, echo, 6'b0} + {3'b000, echo, 4'b0};
    assign prod    = PROD_W'(x) * PROD_W'(DIST_RECIP);
    assign dist_q4 = prod[DIST_SH +: DIST_W];

endmodule

[hw/rtl/eorf_checker.sv]
// Port-level checks for the echo outlier-rejecting filter, bound to the top level.
// Depends on eorf_pkg and echo_outlier_rejecting_filter.
module eorf_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [eorf_pkg::ECHO_W-1:0]  accepted_echo,
    input logic [eorf_pkg::DIST_W-1:0]  distance_q4,
    input logic                         forced_accept,
    input logic                         cfg_valid,
    input logic                         cfg_ready
);
    import eorf_pkg::*;

    logic [63:0] echo_x80;
    logic [63:0] dist_lo;
    logic [63:0] dist_hi;

    assign echo_x80 = 64'(accepted_echo) * 64'd80;
    assign dist_lo  = 64'(distance_q4) * 64'(DIST_DIV);
    assign dist_hi  = (64'(distance_q4) + 64'd1) * 64'(DIST_DIV);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(accepted_echo)
            && $stable(distance_q4) && $stable(forced_accept))
        else $error("result changed while stalled");

    // distance is the truncated quotient of width * 80 / 291
    a_dist: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dist_lo <= echo_x80) && (echo_x80 < dist_hi))
        else $error("distance does not match echo width");

    // input stalls only behind a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // config port never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind echo_outlier_rejecting_filter eorf_checker u_eorf_checker (.*);

[bench/echo_outlier_rejecting_filter_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for echo_outlier_rejecting_filter: directed and random echo widths.
// Holds its own filter predictor; depends on eorf_pkg and the filter RTL.
module echo_outlier_rejecting_filter_test;

    import eorf_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 155;
    localparam int DRAIN_CYCLES = 4;

    typedef struct {
        logic [ECHO_W-1:0] echo;
        logic [DIST_W-1:0] dist_q4;
        logic              forced;
    } echo_result_t;

    class echo_scoreboard;
        logic [ECHO_W-1:0] ring [RING_DEPTH];
        int unsigned       wr_pos;
        logic [TRY_W-1:0]  try_count;
        bit                after_reject;
        logic [ECHO_W-1:0] dev_limit;
        logic [TRY_W-1:0]  retry_limit;
        echo_result_t      pending_q [$];
        int                errors;
        int                n_requests, n_results, n_forced, n_rejected, n_discarded;

        function new();
            for (int i = 0; i < RING_DEPTH; i++)
                ring[i] = '0;
            wr_pos       = 0;
            try_count    = '0;
            after_reject = 0;
            dev_limit    = ECHO_W'(2000);
            retry_limit  = TRY_W'(5);
            errors       = 0;
            n_requests   = 0;
            n_results    = 0;
            n_forced     = 0;
            n_rejected   = 0;
            n_discarded  = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [ECHO_W-1:0] data);
            case (idx)
                CFG_DEV_LIMIT:   dev_limit = data;
                CFG_RETRY_LIMIT: retry_limit = data[TRY_W-1:0];
                default: ;
            endcase
        endfunction

        // Truncated mean of the ring, 0 when any slot is still empty.
        function int unsigned ring_mean();
            longint unsigned sum;
            sum = 0;
            for (int i = 0; i < RING_DEPTH; i++) begin
                if (ring[i] == '0)
                    return 0;
                sum += ring[i];
            end
            return int'(sum / RING_DEPTH);
        endfunction

        function void store_echo(logic [ECHO_W-1:0] echo, logic forced);
            echo_result_t r;
            longint unsigned scaled;
            ring[wr_pos] = echo;
            wr_pos       = (wr_pos + 1) % RING_DEPTH;
            try_count    = '0;
            scaled       = (longint'(echo) * 80) / 291;
            r.echo       = echo;
            r.dist_q4    = scaled[DIST_W-1:0];
            r.forced     = forced;
            pending_q.push_back(r);
            if (forced)
                n_forced++;
        endfunction

        function void note_echo(logic [ECHO_W-1:0] echo);
            int unsigned mean, delta;
            n_requests++;
            if (after_reject) begin
                after_reject = 0;
                if (try_count >= retry_limit)
                    store_echo(echo, 1'b1);
                else
                    n_discarded++;
                return;
            end
            mean = ring_mean();
            if (mean == 0) begin
                store_echo(echo, 1'b0);
                return;
            end
            delta = (echo >= mean) ? (echo - mean) : (mean - echo);
            if (delta < dev_limit) begin
                store_echo(echo, 1'b0);
            end
            else begin
                try_count    = try_count + 1'b1;
                after_reject = 1;
                n_rejected++;
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("mismatch: %s", what);
        endtask

        task check_result(logic [ECHO_W-1:0] echo, logic [DIST_W-1:0] dist_q4, logic forced);
            echo_result_t want;
            if (pending_q.size() == 0) begin
                report($sformatf("result echo=%0d with nothing expected", echo));
                return;
            end
            want = pending_q.pop_front();
            n_results++;
            if (echo !== want.echo)
                report($sformatf("accepted_echo %0d, want %0d", echo, want.echo));
            if (dist_q4 !== want.dist_q4)
                report($sformatf("distance_q4 %0d, want %0d (echo %0d)",
                                 dist_q4, want.dist_q4, want.echo));
            if (forced !== want.forced)
                report($sformatf("forced_accept %0b, want %0b (echo %0d)",
                                 forced, want.forced, want.echo));
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [ECHO_W-1:0] raw_echo = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ECHO_W-1:0] accepted_echo;
    logic [DIST_W-1:0] distance_q4;
    logic              forced_accept;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    cfg_index_t        cfg_index = CFG_DEV_LIMIT;
    logic [ECHO_W-1:0] cfg_data = '0;

    echo_scoreboard sb;

    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          hold_reqs = 0;
    int          holds_seen = 0;
    int          hold_left = 0;
    int unsigned base_echo = 500000;
    int          burst_left = 0;

    echo_outlier_rejecting_filter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .raw_echo      (raw_echo),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .accepted_echo (accepted_echo),
        .distance_q4   (distance_q4),
        .forced_accept (forced_accept),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge clk)
    begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_reqs != holds_seen) begin
            holds_seen <= hold_reqs;
            hold_left  <= HOLD_CYCLES;
            out_ready  <= 1'b0;
        end
        else begin
            out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(accepted_echo, distance_q4, forced_accept);
    end

    function automatic logic [ECHO_W-1:0] clamp_echo(longint v);
        if (v < 1)
            return ECHO_W'(1);
        if (v > 64'hFFFFF)
            return {ECHO_W{1'b1}};
        return v[ECHO_W-1:0];
    endfunction

    // Mostly readings around a moving center, with outlier bursts, timeouts and noise.
    function automatic logic [ECHO_W-1:0] next_echo();
        int unsigned pick;
        longint      spread, off;
        pick = $urandom_range(0, 99);
        if (burst_left > 0) begin
            burst_left--;
            pick = 60;
        end
        if (pick < 55) begin
            spread = sb.dev_limit;
            spread = spread + spread / 2 + 4;
            if (spread > 300000)
                spread = 300000;
            off = longint'($urandom_range(0, 2 * spread)) - spread;
            return clamp_echo(longint'(base_echo) + off);
        end
        else if (pick < 75) begin
            if (pick >= 70)
                burst_left = $urandom_range(1, 31);
            off = longint'(sb.dev_limit) + $urandom_range(0, 200000);
            if ($urandom_range(0, 1) && longint'(base_echo) > off)
                return clamp_echo(longint'(base_echo) - off);
            return clamp_echo(longint'(base_echo) + off);
        end
        else if (pick < 82) begin
            return '0;
        end
        else if (pick < 92) begin
            return ECHO_W'($urandom);
        end
        base_echo = $urandom_range(1, 20'hFFFFF);
        return ECHO_W'(base_echo);
    endfunction

    task send_echo(logic [ECHO_W-1:0] echo);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_echo <= echo;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_echo(echo);
    endtask

    task cfg_write(cfg_index_t idx, logic [ECHO_W-1:0] data, bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, data);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task set_limits(logic [ECHO_W-1:0] dev, logic [TRY_W-1:0] retry);
        logic [ECHO_W-1:0] retry_word;
        // upper bits of the retry word are don't-care; fill them with noise
        retry_word = {ECHO_W'($urandom) << TRY_W} | ECHO_W'(retry);
        cfg_write(CFG_DEV_LIMIT, dev, 1'b0);
        cfg_write(CFG_RETRY_LIMIT, retry_word, 1'b1);
    endtask

    // Idle the sender and let every request drain, including a discarded tail.
    task settle();
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task set_idle(int mode);
        case (mode)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 76; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 76; end
            default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
        endcase
    endtask

    initial
    begin
        #2_000_000;
        $display("echo_outlier_rejecting_filter_test: done, errors");
        $finish;
    end

    initial
    begin
        int unsigned m;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty ring, extremes, filling the ring, rejections up to a forced accept.
        send_echo('0);
        send_echo({ECHO_W{1'b1}});
        send_echo(ECHO_W'(1000000));
        send_echo(ECHO_W'(1000500));
        send_echo(ECHO_W'(1016000));
        repeat (4) begin
            send_echo(ECHO_W'(1));
            send_echo(ECHO_W'(5));
        end
        send_echo(ECHO_W'(1));
        send_echo(ECHO_W'(2));
        // deviation exactly at the limit rejects, one below passes
        m = sb.ring_mean();
        send_echo(ECHO_W'(m + 2000));
        send_echo(ECHO_W'(7));
        send_echo(ECHO_W'(m - 1999));
        send_echo(ECHO_W'(20'h55555));
        send_echo(ECHO_W'(20'hAAAAA));

        for (int p = 0; p < 8; p++) begin
            settle();
            case (p)
                1: set_limits('0, TRY_W'(1));
                2: set_limits({ECHO_W{1'b1}}, TRY_W'(15));
                3: set_limits(ECHO_W'(500), TRY_W'(1));
                4: set_limits(ECHO_W'(3000), TRY_W'(0));
                5: set_limits(ECHO_W'(1), TRY_W'(15));
                6: set_limits(ECHO_W'($urandom), TRY_W'($urandom_range(1, 15)));
                7: set_limits(ECHO_W'(2000), TRY_W'(5));
                default: ;
            endcase
            set_idle(p % 4);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 4 && k == 40)
                    hold_reqs++;
                send_echo(next_echo());
            end
        end
        settle();

        $display("run: %0d readings over 8 limit settings, %0d results checked (%0d forced)",
                 sb.n_requests, sb.n_results, sb.n_forced);
        $display("run: %0d outliers rejected, %0d readings dropped after a rejection",
                 sb.n_rejected, sb.n_discarded);
        if (sb.errors == 0)
            $display("echo_outlier_rejecting_filter_test: done, clean");
        else
            $display("echo_outlier_rejecting_filter_test: done, errors");
        $finish;
    end

endmodule
